// ----- src/icp_pkg.sv -----
// Shared types, constants and helpers of the inline color tag parser.
`default_nettype none
package icp_pkg;

  localparam int UNIT_W    = 16;
  localparam int COLOR_W   = 32;
  localparam int REP_W     = 16;
  localparam int WIN_LEN   = 10;
  localparam int FILL_W    = 4;
  localparam int OUT_TDATA_W = 72;

  localparam logic [UNIT_W-1:0] LBRACE  = 16'h007B;
  localparam logic [UNIT_W-1:0] RBRACE  = 16'h007D;
  localparam logic [UNIT_W-1:0] SPACE_U = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_0    = 16'h0030;
  localparam logic [UNIT_W-1:0] CH_9    = 16'h0039;
  localparam logic [UNIT_W-1:0] CH_UA   = 16'h0041;
  localparam logic [UNIT_W-1:0] CH_UF   = 16'h0046;
  localparam logic [UNIT_W-1:0] CH_LA   = 16'h0061;
  localparam logic [UNIT_W-1:0] CH_LF   = 16'h0066;

  localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 32'hFFFF_FFFF;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EMIT_SPACES,
    OP_SPACE_WRAP,
    OP_SPACE_ADD,
    OP_EMIT_CHAR,
    OP_TAG,
    OP_MARKER,
    OP_FLUSH
  } icp_op_t;

  typedef struct packed {
    icp_op_t op;
  } icp_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic head_brace;
    logic head_space;
    logic held_nz;
    logic held_cap;
    logic wait_more;
    logic tag_ok;
    logic end_flag;
    logic emit_ok;
    logic stg_valid;
    logic out_free;
  } icp_stat_t;

  typedef struct packed {
    logic               kind;
    logic [UNIT_W-1:0]  ch;
    logic [REP_W-1:0]   rep;
    logic [COLOR_W-1:0] color;
    logic               seg;
  } icp_res_t;

  // {valid, value} of one hex digit
  function automatic logic [4:0] hex_nib(input logic [UNIT_W-1:0] c);
    logic [UNIT_W-1:0] d;
    begin
      d = '0;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
        hex_nib = {1'b1, d[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 16'd10;
        hex_nib = {1'b1, d[3:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 16'd10;
        hex_nib = {1'b1, d[3:0]};
      end else begin
        hex_nib = 5'b0;
      end
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/icp_ctrl.sv -----
// Controller state machine of the inline color tag parser.
`default_nettype none
module icp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire icp_pkg::icp_stat_t stat,
  output icp_pkg::icp_cmd_t     cmd
);
  import icp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RESOLVE, S_END, S_FLUSH} state_t;

  state_t state_r, state_nxt;
  logic   rdy_r;
  icp_op_t op;

  assign in_tready = rdy_r;
  assign cmd.op    = op;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && rdy_r) begin
          op        = OP_ACCEPT;
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (stat.fill_zero || (stat.head_brace && stat.wait_more)) begin
          state_nxt = stat.end_flag ? S_END : S_FLUSH;
        end else if (stat.head_brace && stat.tag_ok) begin
          op = OP_TAG;
        end else if (stat.head_space) begin
          if (!stat.held_cap) begin
            op = OP_SPACE_ADD;
          end else if (stat.emit_ok) begin
            op = OP_SPACE_WRAP;
          end
        end else if (stat.emit_ok) begin
          op = stat.held_nz ? OP_EMIT_SPACES : OP_EMIT_CHAR;
        end
      end
      S_END: begin
        if (stat.emit_ok) begin
          if (stat.held_nz) begin
            op = OP_EMIT_SPACES;
          end else begin
            op        = OP_MARKER;
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.stg_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          op        = OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= (state_nxt == S_IDLE);
    end
  end

endmodule
`default_nettype wire

// ----- src/icp_dp.sv -----
// Datapath of the inline color tag parser: window, color, space count, result staging.
`default_nettype none
module icp_dp #(
  parameter int HELD_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [icp_pkg::COLOR_W-1:0] cfg_wdata,
  input  wire logic [icp_pkg::UNIT_W-1:0]  in_unit,
  input  wire logic                       in_end,
  input  wire icp_pkg::icp_cmd_t          cmd,
  output icp_pkg::icp_stat_t              stat,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [icp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import icp_pkg::*;

  localparam int WIN_W = WIN_LEN * UNIT_W;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);
  localparam logic [FILL_W-1:0] FILL_SIX  = FILL_W'(8);

  logic [COLOR_W-1:0]   def_r, cur_r, cur_nxt;
  logic [HELD_BITS-1:0] held_r, held_nxt;
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 sp_r, sp_nxt;
  logic                 in_str_r, in_str_nxt;
  logic                 end_r, end_nxt;
  logic                 stg_v_r, stg_v_nxt;
  icp_res_t             stg_r, stg_nxt;
  logic                 out_v_r, out_v_nxt;
  icp_res_t             out_r, out_nxt;
  logic                 last_r, last_nxt;

  logic [UNIT_W-1:0] head, w7, w9;
  logic [4:0]        nib [1:8];
  logic              hex6, hex8, len8, len6;
  logic [COLOR_W-1:0] tag_color;
  logic              emit, flush;
  icp_res_t          new_res;
  logic [FILL_W-1:0] drop_n;
  logic              out_free;

  assign head = win_r[0 +: UNIT_W];
  assign w7   = win_r[7*UNIT_W +: UNIT_W];
  assign w9   = win_r[9*UNIT_W +: UNIT_W];

  always_comb begin
    for (int k = 1; k <= 8; k++) begin
      nib[k] = hex_nib(win_r[k*UNIT_W +: UNIT_W]);
    end
  end

  assign hex6 = nib[1][4] & nib[2][4] & nib[3][4] & nib[4][4] & nib[5][4] & nib[6][4];
  assign hex8 = hex6 & nib[7][4] & nib[8][4];
  assign len8 = (fill_r == FILL_FULL) && (w9 == RBRACE);
  assign len6 = !len8 && (fill_r >= FILL_SIX) && (w7 == RBRACE);

  // eight digits are RRGGBBAA, six keep the default alpha
  always_comb begin
    if (len8) begin
      tag_color = {nib[7][3:0], nib[8][3:0], nib[1][3:0], nib[2][3:0],
                   nib[3][3:0], nib[4][3:0], nib[5][3:0], nib[6][3:0]};
    end else begin
      tag_color = {def_r[31:24], nib[1][3:0], nib[2][3:0], nib[3][3:0],
                   nib[4][3:0], nib[5][3:0], nib[6][3:0]};
    end
  end

  assign out_free = !out_v_r || out_tready;

  always_comb begin
    stat.fill_zero  = (fill_r == '0);
    stat.head_brace = (head == LBRACE);
    stat.head_space = (head == SPACE_U);
    stat.held_nz    = (held_r != '0);
    stat.held_cap   = (held_r == {HELD_BITS{1'b1}});
    stat.wait_more  = (fill_r < FILL_FULL) && !end_r;
    stat.tag_ok     = (len8 && hex8) || (len6 && hex6);
    stat.end_flag   = end_r;
    stat.emit_ok    = !stg_v_r || out_free;
    stat.stg_valid  = stg_v_r;
    stat.out_free   = out_free;
  end

  always_comb begin
    cur_nxt    = cur_r;
    held_nxt   = held_r;
    fill_nxt   = fill_r;
    sp_nxt     = sp_r;
    in_str_nxt = in_str_r;
    end_nxt    = end_r;
    win_nxt    = win_r;
    drop_n     = '0;
    emit       = 1'b0;
    flush      = 1'b0;
    new_res.kind  = KIND_TEXT;
    new_res.ch    = SPACE_U;
    new_res.rep   = REP_W'(held_r);
    new_res.color = cur_r;
    new_res.seg   = sp_r;

    case (cmd.op)
      OP_ACCEPT: begin
        if (!in_str_r) begin
          cur_nxt    = def_r;
          in_str_nxt = 1'b1;
        end
        for (int k = 0; k < WIN_LEN; k++) begin
          if (fill_r == FILL_W'(k)) begin
            win_nxt[k*UNIT_W +: UNIT_W] = in_unit;
          end
        end
        fill_nxt = fill_r + 1'b1;
        end_nxt  = in_end;
      end
      OP_EMIT_SPACES: begin
        emit     = 1'b1;
        held_nxt = '0;
        sp_nxt   = 1'b0;
      end
      OP_SPACE_WRAP: begin
        emit     = 1'b1;
        held_nxt = HELD_BITS'(1);
        sp_nxt   = 1'b0;
        drop_n   = FILL_W'(1);
      end
      OP_SPACE_ADD: begin
        held_nxt = held_r + 1'b1;
        drop_n   = FILL_W'(1);
      end
      OP_EMIT_CHAR: begin
        emit        = 1'b1;
        new_res.ch  = head;
        new_res.rep = REP_W'(1);
        sp_nxt      = 1'b0;
        drop_n      = FILL_W'(1);
      end
      OP_TAG: begin
        cur_nxt = tag_color;
        sp_nxt  = 1'b1;
        drop_n  = len8 ? FILL_W'(10) : FILL_W'(8);
      end
      OP_MARKER: begin
        emit          = 1'b1;
        new_res.kind  = KIND_MARKER;
        new_res.ch    = '0;
        new_res.rep   = '0;
        new_res.seg   = 1'b0;
        cur_nxt       = def_r;
        held_nxt      = '0;
        fill_nxt      = '0;
        sp_nxt        = 1'b1;
        in_str_nxt    = 1'b0;
        end_nxt       = 1'b0;
      end
      OP_FLUSH: flush = 1'b1;
      default: ;
    endcase

    // drop consumed units off the head of the window
    if (drop_n != '0) begin
      fill_nxt = fill_r - drop_n;
      if (drop_n == FILL_W'(1)) begin
        win_nxt = win_r >> UNIT_W;
      end else if (drop_n == FILL_W'(8)) begin
        win_nxt = win_r >> (8 * UNIT_W);
      end else begin
        // an eight-digit tag fills the whole window
        win_nxt = '0;
      end
    end
  end

  // Staging: a result is held back one step so run_last can be set on the final one
  always_comb begin
    out_v_nxt = out_v_r && !out_tready;
    out_nxt   = out_r;
    last_nxt  = last_r;
    stg_v_nxt = stg_v_r;
    stg_nxt   = stg_r;
    if (emit) begin
      if (stg_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = stg_r;
        last_nxt  = 1'b0;
      end
      stg_nxt   = new_res;
      stg_v_nxt = 1'b1;
    end else if (flush) begin
      out_v_nxt = 1'b1;
      out_nxt   = stg_r;
      last_nxt  = 1'b1;
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_r    <= DEFAULT_COLOR_RST;
      cur_r    <= DEFAULT_COLOR_RST;
      held_r   <= '0;
      fill_r   <= '0;
      sp_r     <= 1'b1;
      in_str_r <= 1'b0;
      end_r    <= 1'b0;
      stg_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        def_r <= cfg_wdata;
      end
      cur_r    <= cur_nxt;
      held_r   <= held_nxt;
      fill_r   <= fill_nxt;
      sp_r     <= sp_nxt;
      in_str_r <= in_str_nxt;
      end_r    <= end_nxt;
      stg_v_r  <= stg_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    stg_r  <= stg_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_r.seg, out_r.color, out_r.rep, out_r.ch};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

// ----- src/inline_color_tag_parser_core.sv -----
// Top level of the inline color tag parser: controller and datapath.
`default_nettype none
// Inline color tag parser. Each request carries one UTF-16 code unit (tlast marks the
// final unit of a string). Tags {RRGGBB} and {RRGGBBAA} change the color and emit
// nothing; a '{' that does not open a valid tag is passed through as text, and the
// units behind it are examined again. A '{' is held until ten units are present or the
// string ends. Spaces are counted and emitted as runs, so spaces just before a tag take
// the new color. Each result is a character or a space run with its ARGB color, plus an
// end-of-string marker after the last unit of a string; tlast flags the last result
// caused by one input request. Each request is accepted, then the resolve sequencer
// steps through the window (a literal, a space or a whole tag at a time, with held
// spaces emitted before a literal), then any held-back result is flushed; at the
// end of a string the held spaces and the marker are emitted first. New requests are
// taken only in idle. Emitting steps stall while staging and output are both full.
module inline_color_tag_parser_core #(
  parameter int SPACE_COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: default color (ARGB)
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] code_unit
  input  wire logic        in_tlast,    // string_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,   // [15:0] char_out, [31:16] repeat_count,
                                        // [63:32] color_argb, [64] segment_start
  output logic             out_tuser,   // kind
  output logic             out_tlast    // run_last
);
  import icp_pkg::*;

  // the held space count never needs more than the 16 bits of repeat_count
  localparam int HELD_BITS = (SPACE_COUNT_BITS < REP_W) ? SPACE_COUNT_BITS : REP_W;

  icp_cmd_t  cmd;
  icp_stat_t stat;

  // controller: walks the window one step per cycle unless a result cannot be staged
  icp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: window, colors, space count, result staging and output register
  icp_dp #(
    .HELD_BITS (HELD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_unit    (in_tdata),
    .in_end     (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
